@@ hdl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key/value cache
// Request and result payload layouts, request kinds and fixed field widths.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Read value returned on a miss and on every store
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // Request kind
  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_STORE  = 1'b1
  } mode_e;

  // One request as held in the input register
  typedef struct packed {
    mode_e                     mode;
    logic signed [KEY_W-1:0]   key;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  // One result as held in the output register
  typedef struct packed {
    logic                      found;
    logic signed [DATA_W-1:0]  read_value;
  } res_t;

endpackage

@@ hdl/lkv_table.sv @@
// ----------------------------------------------------------------------------
// lkv_table: entry table with parallel key match and recency ranking
// Holds keys, values, valid bits and recency ranks. For the request at its
// input it produces the result and, when enabled, applies the table update.
// ----------------------------------------------------------------------------
module lkv_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [lkv_pkg::CAP_W-1:0] cap_i,
  input  lkv_pkg::req_t             req_i,
  output lkv_pkg::res_t             res_o
);
  import lkv_pkg::*;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Entry storage: keys and values need no reset, valid bits gate every read
  logic [KEY_W-1:0]  keys_q   [ENTRIES];
  logic [DATA_W-1:0] vals_q   [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0] rank_q   [ENTRIES];
  logic [RANK_W-1:0] rank_d   [ENTRIES];
  logic [OCC_W-1:0]  occ_q, occ_d;

  logic [ENTRIES-1:0] hit_vec, victim_vec, free_vec;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx, victim_idx, slot_idx;
  logic [RANK_W-1:0]  hit_rank, last_rank;
  logic [CMP_W-1:0]   cap_ext, eff_cap, occ_ext;
  logic               cap_zero, do_insert, do_evict, do_touch;

  // Match every valid entry against the request key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (keys_q[i] == req_i.key);
    end
  end

  assign hit       = |hit_vec;
  assign last_rank = RANK_W'(occ_q - 1'b1);

  // Least recent entry carries rank occupancy-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
  end

  // Clamp capacity to the table size and decide on insertion and eviction
  assign cap_ext   = CMP_W'(cap_i);
  assign eff_cap   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign occ_ext   = CMP_W'(occ_q);
  assign cap_zero  = (cap_i == '0);
  assign do_touch  = hit;
  assign do_insert = (req_i.mode == MODE_STORE) && !hit && !cap_zero;
  assign do_evict  = do_insert && (occ_ext >= eff_cap);

  // Slots open for the new entry: empty ones and the one being evicted
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      free_vec[i] = !valid_q[i] || (do_evict && victim_vec[i]);
    end
  end

  // Pick the lowest set index of each vector
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    slot_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (victim_vec[i]) begin
        victim_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        slot_idx = IDX_W'(i);
      end
    end
  end

  assign hit_rank = rank_q[hit_idx];

  // Result: value on a lookup hit, all ones otherwise
  always_comb begin
    res_o.found      = hit;
    res_o.read_value = MISS_VALUE;
    if (hit && (req_i.mode == MODE_LOOKUP)) begin
      res_o.read_value = vals_q[hit_idx];
    end
  end

  // Next valid bits, ranks and occupancy
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (do_touch) begin
      // Age entries that were more recent than the hit, then promote the hit
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      rank_d[hit_idx] = '0;
    end else if (do_insert) begin
      if (do_evict) begin
        valid_d[victim_idx] = 1'b0;
        rank_d[victim_idx]  = '0;
      end
      // Age every surviving entry, then place the new one as most recent
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_d[i]) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
      valid_d[slot_idx] = 1'b1;
      rank_d[slot_idx]  = '0;
      if (!do_evict) begin
        occ_d = occ_q + 1'b1;
      end
    end
  end

  // Control state: valid bits, ranks, occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (en_i) begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Payload: write the key and value of a new entry, or the value on a store hit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (do_insert) begin
        keys_q[slot_idx] <= req_i.key;
        vals_q[slot_idx] <= req_i.value;
      end else if (hit && (req_i.mode == MODE_STORE)) begin
        vals_q[hit_idx] <= req_i.value;
      end
    end
  end

endmodule

@@ hdl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Lookups and stores against a small table, one result per request.
//
//   Channel  | Dir | Handshake                      | Payload
//   ---------+-----+--------------------------------+------------------------
//   s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser: mode
//            |     |                                | tdata: key, value
//   m_axis   | out | m_axis_tvalid / m_axis_tready  | tuser: found
//            |     |                                | tdata: read_value
//   cfg      | in  | cfg_we_i                       | cfg_wdata_i: capacity
//
// A request is taken into the input register, resolved against the table from
// there and registered into the output register. One request per cycle is
// sustained while the output is not stalled; the table update finishes in
// the same cycle the result is registered, so the next request sees it.
// Reset empties the table at once and sets capacity to 16.
// A stalled output holds its result; the input register still takes one
// request while the result waits, then holds until the output frees up.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // [31:0] key, [63:32] value
  input  logic                       s_axis_tuser,  // [0] mode
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // [31:0] read_value
  output logic                       m_axis_tuser,  // [0] found
  // Capacity register
  input  logic                       cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_wdata_i
);
  import lkv_pkg::*;

  logic             req_vld_q;
  req_t             req_q;
  logic             out_vld_q;
  res_t             out_q;
  res_t             res;
  logic             advance;
  logic             in_xfer;
  logic [CAP_W-1:0] cap_q;

  // Move the held request into the output register when it is free or draining
  assign advance       = req_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !req_vld_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_xfer) begin
      req_vld_q <= 1'b1;
    end else if (advance) begin
      req_vld_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.mode  <= mode_e'(s_axis_tuser);
      req_q.key   <= s_axis_tdata[31:0];
      req_q.value <= s_axis_tdata[63:32];
    end
  end

  lkv_table #(
    .ENTRIES (ENTRIES)
  ) u_lkv_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cap_i  (cap_q),
    .req_i  (req_q),
    .res_o  (res)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.read_value;
  assign m_axis_tuser  = out_q.found;

endmodule

@@ hdl/lkv_checker.sv @@
// ----------------------------------------------------------------------------
// lkv_checker: port-level checks for the LRU key/value cache
// Watches the request, result and reset ports of the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed or dropped");

  // A result without a match always reads all ones
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'hFFFF_FFFF))
    else $error("miss or store result does not read all ones");

  // Refuse a request only while a finished result is stalled
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result pending right after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the LRU key/value cache
// Feeds lookups and stores through the request stream, predicts every result
// with an in-bench LRU table and compares the result stream in order. A short
// directed table comes first, then random phases over several capacities,
// with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import lkv_pkg::*;

  localparam int unsigned ENTRIES          = 16;
  localparam int          PHASES           = 10;
  localparam int          ITEMS_PER_PHASE  = 48;
  localparam int          LONG_HOLD_CYCLES = 64;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          POOL_SIZE        = 24;

  // Capacity used in each random phase: extremes, saturation and zero among them
  localparam int PHASE_CAP [PHASES] = '{16, 1, 4, 31, 0, 16, 2, 8, 17, 16};

  // Directed table rows: a request, or a capacity write taken while idle
  typedef enum logic {
    ROW_REQUEST  = 1'b0,
    ROW_CAPACITY = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    mode_e              mode;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;      // request value, or capacity on a write row
    logic               typed;      // 1: result below is given, 0: predicted
    logic               found;
    logic [DATA_W-1:0]  read_value;
  } stim_row_t;

  localparam int DIRECTED_LEN = 22;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // empty after reset
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    // extreme keys and values
    '{ROW_REQUEST,  MODE_STORE,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_STORE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    // store to a present key overwrites
    '{ROW_REQUEST,  MODE_STORE,  32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, MISS_VALUE},
    // a hit whose stored value equals the miss value
    '{ROW_REQUEST,  MODE_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    // capacity lowered below occupancy: inserts evict one each
    '{ROW_CAPACITY, MODE_LOOKUP, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_STORE,  32'h0000_0001, 32'h1234_5678, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, MISS_VALUE},
    // capacity zero: inserts dropped, resident entries still reachable
    '{ROW_CAPACITY, MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_STORE,  32'h0000_0005, 32'h5555_5555, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_STORE,  32'h8000_0000, 32'hAAAA_AAAA, 1'b0, 1'b0, MISS_VALUE},
    // capacity above the table size saturates
    '{ROW_CAPACITY, MODE_LOOKUP, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_STORE,  32'h0000_0002, 32'hC3C3_C3C3, 1'b0, 1'b0, MISS_VALUE},
    '{ROW_REQUEST,  MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, MISS_VALUE}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;  // [31:0] key, [63:32] value
  logic                s_axis_tuser  = 1'b0;  // [0] mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;  // [31:0] read_value
  logic                m_axis_tuser;  // [0] found
  logic                cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata_i   = '0;

  // In-bench LRU table
  logic [KEY_W-1:0]    line_key   [ENTRIES];
  logic [DATA_W-1:0]   line_value [ENTRIES];
  bit                  line_valid [ENTRIES];
  int                  line_age   [ENTRIES];
  int                  line_count;
  logic [CAP_W-1:0]    cache_capacity;

  res_t                due_results [$];
  int                  mismatch_count = 0;
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];

  // Idling controls shared by the two stream processes
  int                  send_gap_pct    = 0;
  int                  ready_stall_pct = 0;
  bit                  long_hold       = 1'b0;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the LRU table and return its result
  function automatic res_t cache_access(req_t req);
    int   hit;
    int   victim;
    int   slot;
    int   age;
    int   cap;
    res_t res;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && line_valid[i] && line_key[i] == req.key) hit = i;
    end
    res.found      = (hit >= 0);
    res.read_value = MISS_VALUE;
    if (hit >= 0) begin
      if (req.mode == MODE_LOOKUP) res.read_value = line_value[hit];
      else line_value[hit] = req.value;
      // promote the hit entry, age the ones that were more recent
      age = line_age[hit];
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && line_age[i] < age) line_age[i]++;
      end
      line_age[hit] = 0;
    end else if (req.mode == MODE_STORE) begin
      cap = (cache_capacity > ENTRIES) ? ENTRIES : int'(cache_capacity);
      if (cap != 0) begin
        // drop the least recent entry when full
        if (line_count >= cap) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
          end
          if (victim >= 0) begin
            line_valid[victim] = 1'b0;
            line_age[victim]   = 0;
            if (line_count > 0) line_count--;
          end
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !line_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i]) line_age[i]++;
          end
          line_key[slot]   = req.key;
          line_value[slot] = req.value;
          line_valid[slot] = 1'b1;
          line_age[slot]   = 0;
          line_count++;
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  // Keys mostly from a small pool so that hits and evictions occur
  function automatic logic [KEY_W-1:0] pick_key(int span);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return key_pool[$urandom_range(0, span - 1)];
    if (roll < 90) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Offer one request, hold it until the transfer, then queue its result
  task automatic send_request(input req_t req, input bit typed, input res_t given);
    res_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.value, req.key};
    s_axis_tuser  <= req.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = cache_access(req);
    due_results.push_back(typed ? given : predicted);
  endtask

  // Random gap on the request side after a transfer
  task automatic request_gap();
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_cycles()) @(posedge clk_i);
    end
  endtask

  // Drain all results, then write the capacity register
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cache_capacity = cap;
  endtask

  // Request side: reset, directed table, random phases, drain
  initial begin : stimulus
    stim_row_t row;
    req_t      req;
    res_t      given;
    int        span;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_age[i]   = 0;
    end
    line_count     = 0;
    cache_capacity = CAP_RESET;
    foreach (key_pool[i]) key_pool[i] = $urandom();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    send_gap_pct    = 20;
    ready_stall_pct = 20;
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CAPACITY) begin
        write_capacity(row.value[CAP_W-1:0]);
      end else begin
        req.mode         = row.mode;
        req.key          = row.key;
        req.value        = row.value;
        given.found      = row.found;
        given.read_value = row.read_value;
        send_request(req, row.typed, given);
        request_gap();
      end
    end

    // Random phases, one capacity each
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CAP_W'(PHASE_CAP[p]));
      if (p % 3 == 0) foreach (key_pool[i]) key_pool[i] = $urandom();
      span = (PHASE_CAP[p] + 4 < POOL_SIZE) ? PHASE_CAP[p] + 4 : POOL_SIZE;
      if (p == 0) begin
        // back-to-back with the output always ready
        send_gap_pct    = 0;
        ready_stall_pct = 0;
      end else if (p == 3) begin
        // keep offering while the output holds off, so the input backs up
        send_gap_pct    = 0;
        ready_stall_pct = 10;
        long_hold       = 1'b1;
      end else begin
        send_gap_pct    = $urandom_range(0, 40);
        ready_stall_pct = $urandom_range(0, 40);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req.mode  = mode_e'($urandom_range(0, 1));
        req.key   = pick_key(span);
        req.value = $urandom();
        send_request(req, 1'b0, given);
        request_gap();
      end
    end

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold     = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (ready_stall_pct != 0 && $urandom_range(0, 99) < ready_stall_pct) begin
          stall_left = idle_cycles();
        end
      end
    end
  end

  // Compare each result transfer with the oldest queued result
  always @(posedge clk_i) begin : result_check
    res_t due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result found=%0b read_value=%h", $time,
                 m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        due = due_results.pop_front();
        if (m_axis_tuser !== due.found) begin
          $display("%0t: found expected %0b actual %0b", $time, due.found, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata !== due.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, due.read_value,
                   m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop for a hung run
  initial begin : run_limit
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ lru_key_value_cache.f @@
hdl/lkv_pkg.sv
hdl/lkv_table.sv
hdl/lru_key_value_cache.sv
hdl/lkv_checker.sv
dv/tb.sv
